// File: hw/rtl/clit_pkg.sv
// clit_pkg: shared opcodes, bound kinds and the time width
// for the clamped linear interpolation table; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clit_pkg;
    localparam logic [1:0] OP_WRITE_TIME  = 2'd0;
    localparam logic [1:0] OP_WRITE_VALUE = 2'd1;
    localparam logic [1:0] OP_QUERY       = 2'd2;

    localparam logic [1:0] KIND_INTERP = 2'd0;
    localparam logic [1:0] KIND_EXACT  = 2'd1;
    localparam logic [1:0] KIND_BEFORE = 2'd2;
    localparam logic [1:0] KIND_AFTER  = 2'd3;

    localparam int TIME_W = 56;
endpackage
`default_nettype wire

// File: hw/rtl/clamped_linear_interp_table_unit.sv
// clamped_linear_interp_table_unit: top level joining the search front end and
// the channel back end; uses clit_pkg, clit_front, clit_back
//
// usage: items enter on in_valid/in_stall, one transaction each. opcode 0 writes
// a sample time, opcode 1 a channel value, opcode 2 queries a time. a query
// occupies the front end for the edge checks, the search steps and, when
// needed, the upper sample read, plus the serial divide when it interpolates
// and the handoff to the back end; then the back end emits CHANNELS results on
// out_valid/out_stall, one channel at a time, the last one flagged by last,
// and takes no new query until it has emitted them all.
// the front end takes the next item while the back end drains, except that a
// channel value write is stalled until the back end is idle.
// samples_in_use must be written through cfg_valid/cfg_ready while idle; the
// block does not enforce this. reset returns samples_in_use to 1 and clears all
// handshake state; tables stay undefined until written. a stalled result holds
// and the back end waits.
`timescale 1ns / 1ps
`default_nettype none
module clamped_linear_interp_table_unit
    import clit_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int CHANNELS = 16,
    parameter int VALUE_WIDTH = 48,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [5:0]                    sample_index,
    input  wire logic [3:0]                    channel_index,
    input  wire logic signed [VALUE_WIDTH-1:0] channel_value,
    input  wire logic [TIME_W-1:0]             time_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [6:0]                    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [3:0]                         out_channel,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic [1:0]                         bound_kind,
    output logic                               last
);
    localparam int SW = 6;
    localparam int CHW = 4;

    logic [6:0] n_reg;
    logic cmd_valid, cmd_ready, cmd_mix;
    logic [SW-1:0] cmd_a, cmd_b;
    logic [1:0] cmd_kind;
    logic [FRACTION_BITS-1:0] cmd_t;
    logic wr_en;
    logic front_stall;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) n_reg <= 7'd1;
        else if (cfg_valid) n_reg <= cfg_data;
    end

    // value writes wait while the back end still reads the value memory
    assign in_stall = front_stall || (opcode == OP_WRITE_VALUE && !cmd_ready);

    assign wr_en = in_valid && !in_stall && opcode == OP_WRITE_VALUE &&
                   {1'b0, sample_index} < 7'(MAX_SAMPLES) &&
                   {1'b0, channel_index} < 5'(CHANNELS);

    clit_front #(.MAX_SAMPLES(MAX_SAMPLES), .FRACTION_BITS(FRACTION_BITS), .SW(SW), .NW(7))
    u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(front_stall),
        .opcode(opcode), .sample_index(sample_index), .time_value(time_value),
        .n_used(n_reg), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd_a(cmd_a), .cmd_b(cmd_b), .cmd_kind(cmd_kind), .cmd_mix(cmd_mix),
        .cmd_t(cmd_t)
    );

    clit_back #(.MAX_SAMPLES(MAX_SAMPLES), .CHANNELS(CHANNELS), .VALUE_WIDTH(VALUE_WIDTH),
                .FRACTION_BITS(FRACTION_BITS), .SW(SW), .CHW(CHW))
    u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_sample(sample_index),
        .wr_channel(channel_index), .wr_value(channel_value),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_a(cmd_a), .cmd_b(cmd_b),
        .cmd_kind(cmd_kind), .cmd_mix(cmd_mix), .cmd_t(cmd_t),
        .out_valid(out_valid), .out_stall(out_stall), .out_channel(out_channel),
        .out_value(out_value), .bound_kind(bound_kind), .last(last)
    );
endmodule
`default_nettype wire

// File: hw/rtl/clit_front.sv
// clit_front: accepts items, keeps the sample time table, runs the search and
// the serial divide, and hands one query command to the back end; uses clit_pkg
`timescale 1ns / 1ps
`default_nettype none
module clit_front
    import clit_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int FRACTION_BITS = 24,
    parameter int SW = 6,
    parameter int NW = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [SW-1:0]     sample_index,
    input  wire logic [TIME_W-1:0] time_value,
    input  wire logic [NW-1:0]     n_used,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output logic [SW-1:0]          cmd_a,
    output logic [SW-1:0]          cmd_b,
    output logic [1:0]             cmd_kind,
    output logic                   cmd_mix,
    output logic [FRACTION_BITS-1:0] cmd_t
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CMP = 3'd2, S_DIV = 3'd3,
                           S_OUT = 3'd4, S_RDB = 3'd5, S_CMPB = 3'd6;
    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [TIME_W-1:0] times [MAX_SAMPLES];
    logic [TIME_W-1:0] rd_reg;
    logic [SW-1:0] rd_addr;
    logic [2:0] state_reg;
    logic [TIME_W-1:0] q_reg;
    logic [SW-1:0] lo_reg, p_reg, last_reg;
    logic [NW-1:0] size_reg;
    logic [1:0] phase_reg;
    logic [TIME_W-1:0] ta_reg;
    logic [TIME_W:0] rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] a_reg;
    logic [1:0] kind_reg;
    logic mix_reg;
    logic [NW-1:0] n_c;
    logic [NW-1:0] half;
    logic [TIME_W:0] rem_sh;

    assign in_stall = (state_reg != S_IDLE);
    assign half = size_reg >> 1;
    assign rem_sh = {rem_reg[TIME_W-1:0], 1'b0};

    always_comb
    begin
        n_c = n_used;
        if (n_c == '0) n_c = NW'(1);
        if (n_c > NW'(MAX_SAMPLES)) n_c = NW'(MAX_SAMPLES);
    end

    // read address follows the search phase, or the upper sample in S_RDB
    always_comb
    begin
        case (phase_reg)
            2'd0: rd_addr = last_reg;
            2'd1: rd_addr = '0;
            2'd2: rd_addr = p_reg;
            default: rd_addr = lo_reg;
        endcase
        if (state_reg == S_RDB) rd_addr = lo_reg + SW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall && opcode == OP_WRITE_TIME &&
            {1'b0, sample_index} < (SW+1)'(MAX_SAMPLES))
            times[sample_index] <= time_value;
        rd_reg <= times[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                if (in_valid && opcode == OP_QUERY)
                begin
                    q_reg <= time_value;
                    last_reg <= SW'(n_c - NW'(1));
                    lo_reg <= '0;
                    size_reg <= n_c;
                    phase_reg <= 2'd0;
                    mix_reg <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    case (phase_reg)
                        2'd0:
                        if (q_reg > rd_reg)
                        begin
                            a_reg <= last_reg; kind_reg <= KIND_AFTER; state_reg <= S_OUT;
                        end
                        else
                        begin
                            phase_reg <= 2'd1; state_reg <= S_RD;
                        end
                        2'd1:
                        if (q_reg < rd_reg)
                        begin
                            a_reg <= '0; kind_reg <= KIND_BEFORE; state_reg <= S_OUT;
                        end
                        else if (size_reg > NW'(1))
                        begin
                            phase_reg <= 2'd2; p_reg <= lo_reg + SW'(half);
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            phase_reg <= 2'd3; state_reg <= S_RD;
                        end
                        2'd2:
                        begin
                            if (rd_reg == q_reg)
                            begin
                                a_reg <= p_reg; kind_reg <= KIND_EXACT; state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                                if (rd_reg > q_reg)
                                begin
                                    size_reg <= half;
                                    if (half > NW'(1)) p_reg <= lo_reg + SW'(half >> 1);
                                    else phase_reg <= 2'd3;
                                end
                                else
                                begin
                                    lo_reg <= p_reg;
                                    size_reg <= size_reg - half;
                                    if ((size_reg - half) > NW'(1))
                                        p_reg <= p_reg + SW'((size_reg - half) >> 1);
                                    else phase_reg <= 2'd3;
                                end
                            end
                        end
                        default:
                        begin
                            a_reg <= lo_reg;
                            ta_reg <= rd_reg;
                            if (rd_reg == q_reg)
                            begin
                                kind_reg <= KIND_EXACT; state_reg <= S_OUT;
                            end
                            else
                            begin
                                kind_reg <= KIND_INTERP;
                                if ((NW'(lo_reg) + NW'(1)) < n_c)
                                    state_reg <= S_RDB;
                                else state_reg <= S_OUT;
                            end
                        end
                    endcase
                end
                S_RDB: state_reg <= S_CMPB;
                S_CMPB:
                begin
                    if (ta_reg < q_reg && q_reg < rd_reg)
                    begin
                        mix_reg <= 1'b1;
                        rem_reg <= {1'b0, q_reg - ta_reg};
                        den_reg <= rd_reg - ta_reg;
                        quo_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[FRACTION_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[FRACTION_BITS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(FRACTION_BITS - 1)) state_reg <= S_OUT;
                end
                S_OUT: if (cmd_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign cmd_valid = (state_reg == S_OUT);
    assign cmd_a = a_reg;
    assign cmd_b = a_reg + SW'(1);
    assign cmd_kind = kind_reg;
    assign cmd_mix = mix_reg;
    assign cmd_t = quo_reg;
endmodule
`default_nettype wire

// File: hw/rtl/clit_back.sv
// clit_back: holds the channel value memory and produces one result per
// channel for each query command; uses clit_pkg
`timescale 1ns / 1ps
`default_nettype none
module clit_back
    import clit_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int CHANNELS = 16,
    parameter int VALUE_WIDTH = 48,
    parameter int FRACTION_BITS = 24,
    parameter int SW = 6,
    parameter int CHW = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [SW-1:0]                 wr_sample,
    input  wire logic [CHW-1:0]                wr_channel,
    input  wire logic signed [VALUE_WIDTH-1:0] wr_value,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic [SW-1:0]                 cmd_a,
    input  wire logic [SW-1:0]                 cmd_b,
    input  wire logic [1:0]                    cmd_kind,
    input  wire logic                          cmd_mix,
    input  wire logic [FRACTION_BITS-1:0]      cmd_t,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [CHW-1:0]                     out_channel,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic [1:0]                         bound_kind,
    output logic                               last
);
    localparam int AW = SW + CHW;
    localparam int DW = VALUE_WIDTH + 1;
    localparam int HW = DW - FRACTION_BITS;
    localparam int PHW = HW + FRACTION_BITS + 1;
    localparam int PLW = 2 * FRACTION_BITS;
    localparam logic [2:0] B_IDLE = 3'd0, B_RDA = 3'd1, B_RDB = 3'd2, B_MUL = 3'd3,
                           B_SUM = 3'd4, B_OUT = 3'd5;

    logic signed [VALUE_WIDTH-1:0] mem [MAX_SAMPLES * (2 ** CHW)];
    logic signed [VALUE_WIDTH-1:0] rd_reg, va_reg, vb_reg;
    logic [AW-1:0] rd_addr;
    logic [2:0] state_reg;
    logic [CHW-1:0] ch_reg;
    logic [SW-1:0] a_reg, b_reg;
    logic [1:0] kind_reg;
    logic mix_reg;
    logic [FRACTION_BITS-1:0] t_reg;
    logic [PLW-1:0] plo_reg;
    logic signed [PHW-1:0] phi_reg;
    logic signed [DW-1:0] diff;
    logic signed [VALUE_WIDTH-1:0] step;

    assign cmd_ready = (state_reg == B_IDLE);
    assign rd_addr = (state_reg == B_RDB) ? {b_reg, ch_reg} : {a_reg, ch_reg};
    assign diff = DW'(vb_reg) - DW'(va_reg);
    // product split in a low unsigned and a high signed part, joined after the shift
    assign step = VALUE_WIDTH'(phi_reg + PHW'(plo_reg >> FRACTION_BITS));

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[{wr_sample, wr_channel}] <= wr_value;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                if (cmd_valid)
                begin
                    a_reg <= cmd_a; b_reg <= cmd_b; kind_reg <= cmd_kind;
                    mix_reg <= cmd_mix; t_reg <= cmd_t; ch_reg <= '0;
                    state_reg <= B_RDA;
                end
                B_RDA: state_reg <= B_RDB;
                B_RDB:
                begin
                    va_reg <= rd_reg;
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    vb_reg <= rd_reg;
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    plo_reg <= PLW'(diff[FRACTION_BITS-1:0]) * PLW'(t_reg);
                    phi_reg <= PHW'($signed(diff[DW-1:FRACTION_BITS])) *
                               PHW'($signed({1'b0, t_reg}));
                    state_reg <= B_OUT;
                end
                B_OUT:
                if (!out_valid || !out_stall)
                begin
                    out_valid <= 1'b1;
                    out_channel <= ch_reg;
                    out_value <= mix_reg ? va_reg + step : va_reg;
                    bound_kind <= kind_reg;
                    last <= (ch_reg == CHW'(CHANNELS - 1));
                    if (ch_reg == CHW'(CHANNELS - 1)) state_reg <= B_IDLE;
                    else
                    begin
                        ch_reg <= ch_reg + CHW'(1);
                        state_reg <= B_RDA;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
            if (out_valid && !out_stall && !(state_reg == B_OUT))
                out_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire
